[src/cfsr_pkg.sv]
// Shared types and constants for the cofactor signature resub check unit.
// No dependencies; every other source file imports this package.
package cfsr_pkg;

  localparam int WORD_BITS = 32;
  localparam int MAX_CANDS = 6;
  localparam int PAT_BITS  = 6;
  localparam int PAT_COUNT = 64;
  localparam int CNT_W     = 3;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_CANDS);

  typedef struct packed {
    logic [WORD_BITS-1:0] root_word;
    logic [WORD_BITS-1:0] cand_word_0;
    logic [WORD_BITS-1:0] cand_word_1;
    logic [WORD_BITS-1:0] cand_word_2;
    logic [WORD_BITS-1:0] cand_word_3;
    logic [WORD_BITS-1:0] cand_word_4;
    logic [WORD_BITS-1:0] cand_word_5;
    logic                 last_word;
  } in_word_t;

  typedef struct packed {
    logic [PAT_COUNT-1:0] offset_patterns;
    logic [PAT_COUNT-1:0] onset_patterns;
    logic                 compatible;
    logic                 verdict_final;
  } out_word_t;

  // Pattern hits of one bit position.
  typedef struct packed {
    logic [PAT_COUNT-1:0] on_hit;
    logic [PAT_COUNT-1:0] off_hit;
  } lane_hit_t;

endpackage

[src/cfsr_lane.sv]
// One bit-position lane: forms the pattern index from the candidate bits
// and marks it in the onset or offset hit vector. Depends on cfsr_pkg.
module cfsr_lane
  import cfsr_pkg::*;
(
  input  logic [MAX_CANDS-1:0] cand_bits,
  input  logic                 root_bit,
  input  logic [CNT_W-1:0]     cands_used,
  output lane_hit_t            hit
);

  logic [PAT_BITS-1:0]  pat;
  logic [PAT_COUNT-1:0] pat_hot;

  always_comb begin
    pat = '0;
    for (int k = 0; k < MAX_CANDS; k++) begin
      // drop candidates at or above the count in use
      pat[k] = cand_bits[k] & (CNT_W'(k) < cands_used);
    end
  end

  assign pat_hot     = PAT_COUNT'(1) << pat;
  assign hit.on_hit  = root_bit ? pat_hot : '0;
  assign hit.off_hit = root_bit ? '0 : pat_hot;

endmodule

[src/cfsr_merge.sv]
// Merge stage: ORs the lane hits, accumulates the onset/offset masks over a
// test and forms the result word. Depends on cfsr_pkg.
module cfsr_merge
  import cfsr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  lane_hit_t [WORD_BITS-1:0]  lane_hits,
  input  logic                       take,
  input  logic                       last_word,
  output out_word_t                  result
);

  logic [PAT_COUNT-1:0] off_seen_r, off_seen_nxt;
  logic [PAT_COUNT-1:0] on_seen_r, on_seen_nxt;
  logic [PAT_COUNT-1:0] off_word, on_word;
  logic [PAT_COUNT-1:0] off_all, on_all;

  always_comb begin
    off_word = '0;
    on_word  = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      off_word = off_word | lane_hits[b].off_hit;
      on_word  = on_word  | lane_hits[b].on_hit;
    end
  end

  assign off_all = off_seen_r | off_word;
  assign on_all  = on_seen_r  | on_word;

  assign result.offset_patterns = off_all;
  assign result.onset_patterns  = on_all;
  assign result.compatible      = ((off_all & on_all) == '0);
  assign result.verdict_final   = last_word;

  always_comb begin
    off_seen_nxt = off_seen_r;
    on_seen_nxt  = on_seen_r;
    if (take) begin
      // clear at the close of a test
      off_seen_nxt = last_word ? '0 : off_all;
      on_seen_nxt  = last_word ? '0 : on_all;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_seen_r <= '0;
      on_seen_r  <= '0;
    end else begin
      off_seen_r <= off_seen_nxt;
      on_seen_r  <= on_seen_nxt;
    end
  end

endmodule

[src/cofactor_signature_resub_check_unit.sv]
// An accepted input word's result is registered in the output register, or in
// the skid register while the output stalls. Throughput: one word per cycle
// while the skid register is empty; 32 bit-position lanes decode in parallel
// and a single OR merge stage updates the 64-bit masks. An output register
// plus a skid register keep input flowing one word past an output stall.
// Synchronous active-low reset clears masks and buffers and sets node_count to 6.
module cofactor_signature_resub_check_unit
  import cfsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0]                    node_count_r, node_count_nxt;
  logic [CNT_W-1:0]                    cands_used;
  logic [MAX_CANDS-1:0][WORD_BITS-1:0] cand_words;
  lane_hit_t [WORD_BITS-1:0]           lane_hits;
  out_word_t                           result;
  logic                                take;
  logic                                pop;

  out_word_t out_word_r, out_word_nxt;
  out_word_t skid_word_r, skid_word_nxt;
  logic      out_v_r, out_v_nxt;
  logic      skid_v_r, skid_v_nxt;

  assign cfg_ready      = 1'b1;
  assign node_count_nxt = (cfg_valid && cfg_ready) ? cfg_data : node_count_r;
  assign cands_used     = (node_count_r > CNT_W'(MAX_CANDS)) ? CNT_W'(MAX_CANDS)
                                                              : node_count_r;

  assign cand_words[0] = in_data.cand_word_0;
  assign cand_words[1] = in_data.cand_word_1;
  assign cand_words[2] = in_data.cand_word_2;
  assign cand_words[3] = in_data.cand_word_3;
  assign cand_words[4] = in_data.cand_word_4;
  assign cand_words[5] = in_data.cand_word_5;

  for (genvar b = 0; b < WORD_BITS; b++) begin : g_lane
    logic [MAX_CANDS-1:0] cand_bits;
    always_comb begin
      for (int k = 0; k < MAX_CANDS; k++) begin
        cand_bits[k] = cand_words[k][b];
      end
    end
    cfsr_lane u_lane (
      .cand_bits  (cand_bits),
      .root_bit   (in_data.root_word[b]),
      .cands_used (cands_used),
      .hit        (lane_hits[b])
    );
  end

  cfsr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_hits (lane_hits),
    .take      (take),
    .last_word (in_data.last_word),
    .result    (result)
  );

  assign in_ready  = !skid_v_r;
  assign take      = in_valid && in_ready;
  assign pop       = out_v_r && out_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_word_r;

  always_comb begin
    out_word_nxt  = out_word_r;
    skid_word_nxt = skid_word_r;
    out_v_nxt     = out_v_r;
    skid_v_nxt    = skid_v_r;
    if (pop && skid_v_r) begin
      // advance the skid word
      out_word_nxt = skid_word_r;
      skid_v_nxt   = 1'b0;
    end else if (pop || !out_v_r) begin
      out_word_nxt = result;
      out_v_nxt    = take;
    end else if (take) begin
      // hold the stalled word, park the new one
      skid_word_nxt = result;
      skid_v_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_RESET;
      out_v_r      <= 1'b0;
      skid_v_r     <= 1'b0;
    end else begin
      node_count_r <= node_count_nxt;
      out_v_r      <= out_v_nxt;
      skid_v_r     <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

endmodule

[src/cfsr_checker.sv]
// Port-level checks for the cofactor signature resub check unit, attached
// by bind to the top level. Depends on cfsr_pkg.
module cfsr_checker
  import cfsr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  a_compat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.compatible ==
                   ((out_data.offset_patterns & out_data.onset_patterns) == '0)))
    else $error("compatible flag disagrees with masks");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("buffers not empty after reset");

endmodule

bind cofactor_signature_resub_check_unit cfsr_checker u_cfsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
